// ----- rtl/vco_cap_calibration_sequencer_unit_assert.svh -----
// assertion helpers shared by the checker
`ifndef VCO_CAP_CALIBRATION_SEQUENCER_UNIT_ASSERT_SVH
`define VCO_CAP_CALIBRATION_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VCCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vccs assertion failed");

// next-cycle implication, disabled during reset
`define VCCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vccs assertion failed");

`endif

// ----- rtl/vccs_pkg.sv -----
package vccs_pkg;

   localparam int unsigned CAP_W = 6;

   localparam logic [CAP_W-1:0] CAP_START = 6'd31;
   localparam logic [CAP_W-1:0] CAP_MAX   = 6'd63;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   localparam logic [1:0] VT_CODE0 = 2'd0;
   localparam logic [1:0] VT_CODE1 = 2'd1;
   localparam logic [1:0] VT_CODE2 = 2'd2;
   localparam logic [1:0] VT_CODE3 = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_FIRST,
      PH_A_DOWN,
      PH_A_UP,
      PH_B_DOWN1,
      PH_B_DOWN2,
      PH_C_UP1,
      PH_C_UP2
   } phase_type;

   typedef struct packed {
      logic [CAP_W-1:0] cap_value;
      logic             write_valid;
      logic             done_res;
      logic             error;
      logic             last;
   } result_type;

   typedef struct packed {
      phase_type        phase;
      logic [CAP_W-1:0] cap;
      logic [CAP_W-1:0] cap_low;
      result_type       res0;
      result_type       res1;
      logic [1:0]       count;
   } step_type;

   // final cap from the low and high bounds: (3*high + low + 2) >> 2
   function automatic logic [CAP_W-1:0] finish_cap(input logic [CAP_W-1:0] high,
                                                   input logic [CAP_W-1:0] low);
      logic [CAP_W+1:0] sum;
      sum = {2'b00, high} + {1'b0, high, 1'b0} + {2'b00, low} + (CAP_W+2)'(2);
      return sum[CAP_W+1:2];
   endfunction

   function automatic result_type make_res(input logic [CAP_W-1:0] cap,
                                           input logic wv,
                                           input logic dn,
                                           input logic er);
      result_type r;
      r.cap_value   = cap;
      r.write_valid = wv;
      r.done_res    = dn;
      r.error       = er;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/vccs_if.sv -----
interface vccs_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] vtune_raw;

   modport source (output valid, output mode, output vtune_raw, input ready);
   modport sink (input valid, input mode, input vtune_raw, output ready);
endinterface

interface vccs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vccs_pkg::CAP_W-1:0]  cap_value;
   logic                        write_valid;
   logic                        done_res;
   logic                        error;
   logic                        last;

   modport source (output valid, output cap_value, output write_valid, output done_res,
                   output error, output last, input ready);
   modport sink (input valid, input cap_value, input write_valid, input done_res,
                 input error, input last, output ready);
endinterface

// ----- rtl/vccs_step.sv -----
module vccs_step (
   input  logic                       mode,
   input  logic [7:0]                 vtune_raw,
   input  vccs_pkg::phase_type        phase,
   input  logic [vccs_pkg::CAP_W-1:0] cap_now,
   input  logic [vccs_pkg::CAP_W-1:0] cap_low,
   output vccs_pkg::step_type         step
);

   logic [1:0]                 vt;
   logic                       can_down;
   logic                       can_up;
   logic [vccs_pkg::CAP_W-1:0] cap_dn;
   logic [vccs_pkg::CAP_W-1:0] cap_up;
   logic [vccs_pkg::CAP_W-1:0] fin;

   assign vt       = vtune_raw[7:6];
   assign can_down = (cap_now != '0);
   assign can_up   = (cap_now != vccs_pkg::CAP_MAX);
   assign cap_dn   = cap_now - vccs_pkg::CAP_W'(1);
   assign cap_up   = cap_now + vccs_pkg::CAP_W'(1);

   always_comb begin
      step.phase   = phase;
      step.cap     = cap_now;
      step.cap_low = cap_low;
      step.res0    = '0;
      step.res1    = '0;
      step.count   = 2'd0;
      fin          = '0;

      if (mode == vccs_pkg::MODE_START) begin
         step.phase = vccs_pkg::PH_FIRST;
         step.cap   = vccs_pkg::CAP_START;
         step.res0  = vccs_pkg::make_res(vccs_pkg::CAP_START, 1'b1, 1'b0, 1'b0);
         step.count = 2'd1;
      end else begin
         unique case (phase)
            vccs_pkg::PH_IDLE: begin
               // readings while idle are dropped
            end
            vccs_pkg::PH_FIRST: begin
               step.count = 2'd1;
               unique case (vt)
                  vccs_pkg::VT_CODE0: begin
                     step.cap   = cap_dn;
                     step.res0  = vccs_pkg::make_res(cap_dn, 1'b1, 1'b0, 1'b0);
                     step.phase = vccs_pkg::PH_A_DOWN;
                  end
                  vccs_pkg::VT_CODE1: begin
                     step.cap   = cap_dn;
                     step.res0  = vccs_pkg::make_res(cap_dn, 1'b1, 1'b0, 1'b0);
                     step.phase = vccs_pkg::PH_B_DOWN1;
                  end
                  vccs_pkg::VT_CODE2: begin
                     step.cap   = cap_up;
                     step.res0  = vccs_pkg::make_res(cap_up, 1'b1, 1'b0, 1'b0);
                     step.phase = vccs_pkg::PH_C_UP1;
                  end
                  default: begin
                     step.res0  = vccs_pkg::make_res(cap_now, 1'b0, 1'b0, 1'b1);
                     step.phase = vccs_pkg::PH_IDLE;
                  end
               endcase
            end
            vccs_pkg::PH_A_DOWN: begin
               if (vt != vccs_pkg::VT_CODE2 && can_down) begin
                  step.cap   = cap_dn;
                  step.res0  = vccs_pkg::make_res(cap_dn, 1'b1, 1'b0, 1'b0);
                  step.count = 2'd1;
               end else begin
                  // low bound found: restart at mid scale and search upward, or finish on code 1
                  step.cap_low = cap_now;
                  step.res0    = vccs_pkg::make_res(vccs_pkg::CAP_START, 1'b1, 1'b0, 1'b0);
                  step.count   = 2'd2;
                  if (vt != vccs_pkg::VT_CODE1) begin
                     step.cap   = vccs_pkg::CAP_START + vccs_pkg::CAP_W'(1);
                     step.res1  = vccs_pkg::make_res(step.cap, 1'b1, 1'b0, 1'b0);
                     step.phase = vccs_pkg::PH_A_UP;
                  end else begin
                     fin        = vccs_pkg::finish_cap(vccs_pkg::CAP_START, cap_now);
                     step.cap   = fin;
                     step.res1  = vccs_pkg::make_res(fin, 1'b1, 1'b1, 1'b0);
                     step.phase = vccs_pkg::PH_IDLE;
                  end
               end
            end
            vccs_pkg::PH_A_UP, vccs_pkg::PH_C_UP2: begin
               step.count = 2'd1;
               if (vt != vccs_pkg::VT_CODE1 && can_up) begin
                  step.cap  = cap_up;
                  step.res0 = vccs_pkg::make_res(cap_up, 1'b1, 1'b0, 1'b0);
               end else begin
                  fin        = vccs_pkg::finish_cap(cap_now, cap_low);
                  step.cap   = fin;
                  step.res0  = vccs_pkg::make_res(fin, 1'b1, 1'b1, 1'b0);
                  step.phase = vccs_pkg::PH_IDLE;
               end
            end
            vccs_pkg::PH_B_DOWN1: begin
               step.count = 2'd1;
               if (vt != vccs_pkg::VT_CODE0 && can_down) begin
                  step.cap  = cap_dn;
                  step.res0 = vccs_pkg::make_res(cap_dn, 1'b1, 1'b0, 1'b0);
               end else begin
                  step.cap_low = cap_now;
                  if (vt != vccs_pkg::VT_CODE2 && can_down) begin
                     step.cap   = cap_dn;
                     step.res0  = vccs_pkg::make_res(cap_dn, 1'b1, 1'b0, 1'b0);
                     step.phase = vccs_pkg::PH_B_DOWN2;
                  end else begin
                     fin        = vccs_pkg::finish_cap(cap_now, cap_now);
                     step.cap   = fin;
                     step.res0  = vccs_pkg::make_res(fin, 1'b1, 1'b1, 1'b0);
                     step.phase = vccs_pkg::PH_IDLE;
                  end
               end
            end
            vccs_pkg::PH_B_DOWN2: begin
               step.count = 2'd1;
               if (vt != vccs_pkg::VT_CODE2 && can_down) begin
                  step.cap  = cap_dn;
                  step.res0 = vccs_pkg::make_res(cap_dn, 1'b1, 1'b0, 1'b0);
               end else begin
                  fin        = vccs_pkg::finish_cap(cap_now, cap_low);
                  step.cap   = fin;
                  step.res0  = vccs_pkg::make_res(fin, 1'b1, 1'b1, 1'b0);
                  step.phase = vccs_pkg::PH_IDLE;
               end
            end
            vccs_pkg::PH_C_UP1: begin
               step.count = 2'd1;
               if (vt != vccs_pkg::VT_CODE0 && can_up) begin
                  step.cap  = cap_up;
                  step.res0 = vccs_pkg::make_res(cap_up, 1'b1, 1'b0, 1'b0);
               end else begin
                  step.cap_low = cap_now;
                  if (vt != vccs_pkg::VT_CODE1 && can_up) begin
                     step.cap   = cap_up;
                     step.res0  = vccs_pkg::make_res(cap_up, 1'b1, 1'b0, 1'b0);
                     step.phase = vccs_pkg::PH_C_UP2;
                  end else begin
                     fin        = vccs_pkg::finish_cap(cap_now, cap_now);
                     step.cap   = fin;
                     step.res0  = vccs_pkg::make_res(fin, 1'b1, 1'b1, 1'b0);
                     step.phase = vccs_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      step.res0.last = (step.count == 2'd1);
      step.res1.last = 1'b1;
   end

endmodule

// ----- rtl/vco_cap_calibration_sequencer_unit.sv -----
// Capacitor calibration sequencer for a VCO. A start transaction (mode 0) writes
// cap 31; each comparator reading (mode 1) then steps the search and yields zero,
// one or two result transactions, the final one carrying done_res with the cap
// (3*high+low+2)>>2, or error when the first vtune code is 3. Readings while idle
// give no result. The search step for an accepted transaction is combinational
// from the request and the search state, and its results land in a two-entry
// result buffer. A transaction is taken every cycle as long as it causes at most
// one result and rsp_ch.ready is high while a result is pending; after one that
// causes two, req_ch.ready stays low until the first of the two results leaves.
// The first result is registered and shown in the cycle after acceptance.
module vco_cap_calibration_sequencer_unit (
   input  logic               clock,
   input  logic               reset,
   vccs_req_if.sink           req_ch,
   vccs_rsp_if.source         rsp_ch
);

   vccs_pkg::phase_type        phase_ff, phase_in;
   logic [vccs_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [vccs_pkg::CAP_W-1:0] low_ff, low_in;
   vccs_pkg::result_type       slot0_ff, slot0_in;
   vccs_pkg::result_type       slot1_ff, slot1_in;
   logic [1:0]                 cnt_ff, cnt_in;
   vccs_pkg::step_type         step;
   logic                       accept;
   logic                       pop;

   vccs_step u_step (
      .mode      (req_ch.mode),
      .vtune_raw (req_ch.vtune_raw),
      .phase     (phase_ff),
      .cap_now   (cap_ff),
      .cap_low   (low_ff),
      .step      (step)
   );

   assign pop          = (cnt_ff != 2'd0) && rsp_ch.ready;
   // room for two results once the head leaves
   assign req_ch.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      phase_in = phase_ff;
      cap_in   = cap_ff;
      low_in   = low_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         phase_in = step.phase;
         cap_in   = step.cap;
         low_in   = step.cap_low;
         // buffer is empty or drains its only entry this cycle
         slot0_in = step.res0;
         slot1_in = step.res1;
         cnt_in   = step.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= vccs_pkg::PH_IDLE;
         cap_ff   <= vccs_pkg::CAP_START;
         low_ff   <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         cap_ff   <= cap_in;
         low_ff   <= low_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_ch.valid       = (cnt_ff != 2'd0);
   assign rsp_ch.cap_value   = slot0_ff.cap_value;
   assign rsp_ch.write_valid = slot0_ff.write_valid;
   assign rsp_ch.done_res    = slot0_ff.done_res;
   assign rsp_ch.error       = slot0_ff.error;
   assign rsp_ch.last        = slot0_ff.last;

endmodule

// ----- rtl/vccs_chk.sv -----
`include "vco_cap_calibration_sequencer_unit_assert.svh"

module vccs_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [vccs_pkg::CAP_W-1:0] cap_value,
   input logic                       write_valid,
   input logic                       done_res,
   input logic                       error,
   input logic                       last
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // the final cap write closes the transaction's results
   `VCCS_ASSERT_IMP(a_done_is_last_write, clock, reset, rsp_valid && done_res, write_valid && last && !error)

   // an abort carries no write and the start cap
   `VCCS_ASSERT_IMP(a_error_form, clock, reset, rsp_valid && error, !write_valid && last && !done_res && cap_value == vccs_pkg::CAP_START)

   // a result that is not the last one is followed at once by another
   `VCCS_ASSERT_NXT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !last, rsp_valid)

   // a stalled result holds
   `VCCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(cap_value) && $stable(last) && $stable(done_res))

   // a pending non-last result blocks new requests
   `VCCS_ASSERT_IMP(a_no_take_midpair, clock, reset, rsp_valid && !last, !req_take)

endmodule

bind vco_cap_calibration_sequencer_unit vccs_chk u_vccs_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .cap_value   (rsp_ch.cap_value),
   .write_valid (rsp_ch.write_valid),
   .done_res    (rsp_ch.done_res),
   .error       (rsp_ch.error),
   .last        (rsp_ch.last)
);

// ----- tb/cap_search_checker.sv -----
`timescale 1ns / 1ps

module cap_search_checker
   import vccs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   vccs_req_if        req_ch,
   vccs_rsp_if        rsp_ch,
   output int         mismatch_count,
   output int         outstanding
);

   phase_type        search_phase;
   logic [CAP_W-1:0] cap_now;
   logic [CAP_W-1:0] cap_low;
   result_type       expected_caps[$];

   function automatic void emit_write(input logic [CAP_W-1:0] cap, input logic wv,
                                      input logic dn, input logic er);
      result_type r;
      r.cap_value   = cap;
      r.write_valid = wv;
      r.done_res    = dn;
      r.error       = er;
      r.last        = 1'b0;
      expected_caps.push_back(r);
   endfunction

   function automatic void step_cap(input logic up);
      cap_now = up ? cap_now + 1'b1 : cap_now - 1'b1;
      emit_write(cap_now, 1'b1, 1'b0, 1'b0);
   endfunction

   // final cap is a 3:1 blend of the high and low bounds, rounded
   function automatic void close_search(input logic [CAP_W-1:0] high);
      int sum;
      sum = 3 * int'(high) + int'(cap_low) + 2;
      cap_now = CAP_W'(sum >> 2);
      emit_write(cap_now, 1'b1, 1'b1, 1'b0);
      search_phase = PH_IDLE;
   endfunction

   function automatic void advance_search(input logic mode, input logic [7:0] raw);
      logic [1:0] code;
      logic       can_down;
      logic       can_up;
      int         queued_at_entry;
      result_type tail;
      code            = raw[7:6];
      queued_at_entry = expected_caps.size();
      can_down        = cap_now > '0;
      can_up          = cap_now < CAP_MAX;
      if (mode == MODE_START) begin
         search_phase = PH_FIRST;
         cap_now      = CAP_START;
         emit_write(cap_now, 1'b1, 1'b0, 1'b0);
      end else begin
         case (search_phase)
            PH_FIRST: begin
               if (code == VT_CODE0) begin
                  step_cap(1'b0);
                  search_phase = PH_A_DOWN;
               end else if (code == VT_CODE1) begin
                  step_cap(1'b0);
                  search_phase = PH_B_DOWN1;
               end else if (code == VT_CODE2) begin
                  step_cap(1'b1);
                  search_phase = PH_C_UP1;
               end else begin
                  emit_write(cap_now, 1'b0, 1'b0, 1'b1);
                  search_phase = PH_IDLE;
               end
            end
            PH_A_DOWN: begin
               if (code != VT_CODE2 && can_down) begin
                  step_cap(1'b0);
               end else begin
                  // low bound found, upper search restarts from the midpoint
                  cap_low = cap_now;
                  cap_now = CAP_START;
                  emit_write(cap_now, 1'b1, 1'b0, 1'b0);
                  if (code != VT_CODE1 && cap_now < CAP_MAX) begin
                     step_cap(1'b1);
                     search_phase = PH_A_UP;
                  end else begin
                     close_search(cap_now);
                  end
               end
            end
            PH_A_UP: begin
               if (code != VT_CODE1 && can_up) step_cap(1'b1);
               else close_search(cap_now);
            end
            PH_B_DOWN1: begin
               if (code != VT_CODE0 && can_down) begin
                  step_cap(1'b0);
               end else begin
                  cap_low = cap_now;
                  if (code != VT_CODE2 && can_down) begin
                     step_cap(1'b0);
                     search_phase = PH_B_DOWN2;
                  end else begin
                     close_search(cap_now);
                  end
               end
            end
            PH_B_DOWN2: begin
               if (code != VT_CODE2 && can_down) step_cap(1'b0);
               else close_search(cap_now);
            end
            PH_C_UP1: begin
               if (code != VT_CODE0 && can_up) begin
                  step_cap(1'b1);
               end else begin
                  cap_low = cap_now;
                  if (code != VT_CODE1 && can_up) begin
                     step_cap(1'b1);
                     search_phase = PH_C_UP2;
                  end else begin
                     close_search(cap_now);
                  end
               end
            end
            PH_C_UP2: begin
               if (code != VT_CODE1 && can_up) step_cap(1'b1);
               else close_search(cap_now);
            end
            default: ;
         endcase
      end
      if (expected_caps.size() > queued_at_entry) begin
         tail      = expected_caps.pop_back();
         tail.last = 1'b1;
         expected_caps.push_back(tail);
      end
   endfunction

   task automatic flag_mismatch(input string what, input result_type want,
                                input result_type got);
      if (mismatch_count < 10)
         $display("cap write %s: expected cap %0d wv %0b done %0b err %0b last %0b, %s",
                  what, want.cap_value, want.write_valid, want.done_res, want.error,
                  want.last,
                  $sformatf("got cap %0d wv %0b done %0b err %0b last %0b",
                            got.cap_value, got.write_valid, got.done_res, got.error,
                            got.last));
      mismatch_count <= mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         search_phase = PH_IDLE;
         cap_now      = CAP_START;
         cap_low      = '0;
         expected_caps.delete();
         outstanding <= 0;
      end else begin
         // results first: a result never stems from a transaction at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.cap_value   = rsp_ch.cap_value;
            got.write_valid = rsp_ch.write_valid;
            got.done_res    = rsp_ch.done_res;
            got.error       = rsp_ch.error;
            got.last        = rsp_ch.last;
            if (expected_caps.size() == 0) begin
               flag_mismatch("with none pending", '0, got);
            end else begin
               want = expected_caps.pop_front();
               if (got.cap_value !== want.cap_value || got.write_valid !== want.write_valid ||
                   got.done_res !== want.done_res || got.error !== want.error ||
                   got.last !== want.last)
                  flag_mismatch("mismatch", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready)
            advance_search(req_ch.mode, req_ch.vtune_raw);
         outstanding <= expected_caps.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import vccs_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int N_DIRECTED   = 23;

   // mode in the top bit, comparator byte below
   localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
      {MODE_READ,  8'hFF},   // reading with nothing running
      {MODE_START, 8'hFF},
      {MODE_READ,  8'hC0},   // first code 3 aborts
      {MODE_START, 8'h00},
      {MODE_READ,  8'h3F},   // code 0: search down
      {MODE_READ,  8'h80},   // low found, back to 31 and one step up
      {MODE_READ,  8'h40},   // high found
      {MODE_START, 8'h55},
      {MODE_READ,  8'h00},
      {MODE_READ,  8'h40},   // code 1 keeps the downward search going
      {MODE_START, 8'hAA},
      {MODE_READ,  8'h40},   // code 1: search down twice
      {MODE_READ,  8'h00},
      {MODE_READ,  8'h80},
      {MODE_START, 8'h3F},
      {MODE_READ,  8'hBF},   // code 2: search up twice
      {MODE_READ,  8'h7F},
      {MODE_READ,  8'h00},
      {MODE_READ,  8'h40},
      {MODE_START, 8'hC0},
      {MODE_READ,  8'h1F},
      {MODE_START, 8'h00},   // restart in the middle of a search
      {MODE_READ,  8'hFF}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   outstanding;
   int   cycle_count = 0;
   int   items_sent  = 0;
   bit   steady      = 1'b0;   // no idle cycles on either side

   vccs_req_if req_bus ();
   vccs_rsp_if rsp_bus ();

   vco_cap_calibration_sequencer_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   cap_search_checker i_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [1:0] other_code(input logic [1:0] avoid);
      logic [1:0] c;
      do c = 2'($urandom); while (c == avoid);
      return c;
   endfunction

   function automatic int search_length();
      // long runs walk the cap into its bounds
      return ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
   endfunction

   task automatic send_item(input logic mode, input logic [7:0] raw, input bit counted);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.vtune_raw <= raw;
      do @(posedge clock); while (!req_bus.ready);
      if (counted) items_sent++;
   endtask

   task automatic send_reading(input logic [1:0] code);
      send_item(MODE_READ, {code, 6'($urandom)}, 1'b1);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_calibration();
      logic [1:0] first;
      logic [1:0] stop_low;
      logic [1:0] stop_high;
      int         run_low;
      int         run_high;
      int         cut;
      send_item(MODE_START, 8'($urandom), 1'b1);
      first = ($urandom_range(0, 15) == 0) ? VT_CODE3 : 2'($urandom_range(0, 2));
      send_reading(first);
      // sometimes the search is dropped part way by the next start
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : -1;
      if (first != VT_CODE3) begin
         stop_low  = (first == VT_CODE0) ? VT_CODE2 : VT_CODE0;
         stop_high = (first == VT_CODE1) ? VT_CODE2 : VT_CODE1;
         run_low   = search_length();
         run_high  = search_length();
         for (int i = 0; i < run_low + run_high + 2 && i != cut; i++) begin
            if (i == run_low)
               send_reading(stop_low);
            else if (i == run_low + run_high + 1)
               send_reading(stop_high);
            else if ($urandom_range(0, 19) == 0)
               send_reading(2'($urandom));
            else
               send_reading(other_code(i < run_low ? stop_low : stop_high));
         end
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_item(MODE_READ, 8'($urandom), 1'b0);
   endtask

   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.mode      = MODE_START;
      req_bus.vtune_raw = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_item(DIRECTED[i][8], DIRECTED[i][7:0], 1'b1);
      drain_results();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) steady = !steady;
         if ($urandom_range(0, 15) == 0) drain_results();
         run_calibration();
      end
      drain_results();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
